// ----- rtl/core/psri_pkg.sv -----
// ----------------------------------------------------------------------------
// psri_pkg
// Shared types, codes and constants of the plane query pipeline.
// ----------------------------------------------------------------------------
package psri_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REQ_POINT   = 2'd0,
    REQ_SEGMENT = 2'd1,
    REQ_RAY     = 2'd2,
    REQ_SPARE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_BACK     = 3'd1,
    ST_FRONT    = 3'd2,
    ST_INSIDE   = 3'd3,
    ST_PARALLEL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_NX  = 3'd0,
    CFG_NY  = 3'd1,
    CFG_NZ  = 3'd2,
    CFG_OFS = 3'd3,
    CFG_TOL = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] signed_distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } out_item_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = 66'sh0_7FFF_FFFF;
    mn = -66'sh0_8000_0000;
    if (x > mx) sat32 = 32'sh7FFF_FFFF;
    else if (x < mn) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

endpackage

// ----- rtl/core/plane_segment_ray_intersect.sv -----
// ----------------------------------------------------------------------------
// plane_segment_ray_intersect
// Plane query pipeline: point classify, segment and ray intersection.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ channel writes the plane (normal, offset, tolerance) by index;
//   write only while no query is in flight.
//   in_ channel takes one query beat per cycle while in_ready is high: request type, point P and
//   direction V. out_ channel returns exactly one result beat per query,
//   in order: status, signed distance and the hit point.
// Depth: FRAC_BITS + 39 register stages, FRAC_BITS being 16 (Q16.16) by
//   default: three dot product stages, a divider of one quotient bit per
//   stage (FRAC_BITS+34 stages), the t stage and the output register. The
//   divider depth sets the latency; throughput is one beat per cycle while
//   the pipeline is not stalled.
// Stall: the whole pipeline holds while the output register is full and
//   out_ready is low; in_ready follows the same condition, so nothing is
//   lost or repeated.
// Reset: synchronous active-low rst_n clears the valid bits and loads the
//   default plane z = 0 with normal (0,0,1.0) and tolerance 66.
// ----------------------------------------------------------------------------
module plane_segment_ray_intersect import psri_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int SW = 2 + 3 + 32 + 96 + 96 + 1;

  // configuration
  logic signed [31:0] nx_r, ny_r, nz_r, ofs_r;
  logic [30:0]        tol_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= 32'sd1 <<< FRAC_BITS;
      ofs_r <= '0;
      tol_r <= 31'd66;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NX:  nx_r  <= cfg_data;
        CFG_NY:  ny_r  <= cfg_data;
        CFG_NZ:  nz_r  <= cfg_data;
        CFG_OFS: ofs_r <= cfg_data;
        CFG_TOL: tol_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: six products
  logic        v1_r;
  in_item_t    d1_r;
  logic signed [63:0] pp_r [3];
  logic signed [63:0] pv_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= in_data;
      pp_r[0] <= nx_r * in_data.px;
      pp_r[1] <= ny_r * in_data.py;
      pp_r[2] <= nz_r * in_data.pz;
      pv_r[0] <= nx_r * in_data.vx;
      pv_r[1] <= ny_r * in_data.vy;
      pv_r[2] <= nz_r * in_data.vz;
    end
  end

  // stage 2: exact sums, floor, offset
  logic        v2_r;
  in_item_t    d2_r;
  logic signed [65:0] s_r, nv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d2_r <= d1_r;
      s_r  <= ((66'(pp_r[0]) + 66'(pp_r[1]) + 66'(pp_r[2])) >>> FRAC_BITS) + 66'(ofs_r);
      nv_r <= (66'(pv_r[0]) + 66'(pv_r[1]) + 66'(pv_r[2])) >>> FRAC_BITS;
    end
  end

  // stage 3: zero tests, classification, divider operands
  logic        v3_r;
  in_item_t    d3_r;
  logic [2:0]  st3_r;
  logic        div3_r;
  logic signed [31:0] ss3_r, nvs3_r;
  logic [65:0] s_abs, nv_abs;
  logic        s_zero, nv_zero, is_seg;
  always_comb begin
    s_abs   = s_r[65] ? 66'(-s_r) : 66'(s_r);
    nv_abs  = nv_r[65] ? 66'(-nv_r) : 66'(nv_r);
    s_zero  = s_abs <= 66'(tol_r);
    nv_zero = nv_abs <= 66'(tol_r);
    is_seg  = (d2_r.req_type == REQ_SEGMENT) || (d2_r.req_type == REQ_RAY);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3_r   <= d2_r;
      ss3_r  <= sat32(s_r);
      nvs3_r <= sat32(nv_r);
      div3_r <= is_seg && !nv_zero;
      if (is_seg) st3_r <= s_zero ? ST_INSIDE : ST_PARALLEL;
      else if (s_zero) st3_r <= ST_HIT;
      else if (s_r[65]) st3_r <= ST_BACK;
      else st3_r <= ST_FRONT;
    end
  end

  // divider: t = -s * 2^F / nv, one spare bit so that -(-2^31) fits
  logic signed [NW-1:0] num;
  logic signed [31:0]   den;
  logic [SW-1:0]        side_in, side_out;
  logic                 dv;
  logic signed [NW:0]   quo;
  assign num = -($signed({{(FRAC_BITS+1){ss3_r[31]}}, ss3_r}) <<< FRAC_BITS);
  assign den = div3_r ? nvs3_r : 32'sd1;
  assign side_in = {d3_r.req_type, st3_r, ss3_r, d3_r.px, d3_r.py, d3_r.pz,
                    d3_r.vx, d3_r.vy, d3_r.vz, div3_r};

  psri_div #(.NW(NW), .DW(32), .SW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v3_r),
    .num(num), .den(den), .side_in(side_in),
    .out_valid(dv), .quo(quo), .side_out(side_out)
  );

  logic [1:0]  rq4;
  logic [2:0]  st4;
  logic signed [31:0] sd4, p4 [3], vv4 [3];
  logic        dv4;
  assign {rq4, st4, sd4, p4[0], p4[1], p4[2], vv4[0], vv4[1], vv4[2], dv4}
    = side_out;

  // stage t: saturate t, range check, products V*t
  logic        v5_r;
  logic [2:0]  st5_r;
  logic        hit5_r;
  logic signed [31:0] sd5_r, p5_r [3];
  logic signed [63:0] vt_r [3];
  logic signed [31:0] t_s;
  logic signed [32:0] one;
  always_comb begin
    t_s = sat32(66'(quo));
    one = 33'sd1 <<< FRAC_BITS;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r  <= sd4;
      p5_r   <= p4;
      hit5_r <= 1'b0;
      st5_r  <= st4;
      if (dv4) begin
        if (rq4 == REQ_SEGMENT && t_s < 0) st5_r <= ST_BACK;
        else if (rq4 == REQ_SEGMENT && 33'(t_s) > one) st5_r <= ST_FRONT;
        else begin
          st5_r  <= ST_HIT;
          hit5_r <= 1'b1;
        end
      end
      for (int i = 0; i < 3; i++) vt_r[i] <= vv4[i] * t_s;
    end
  end

  // output register: hit = P + floor(V*t), saturated
  out_item_t od_r;
  logic      ov_r;
  logic signed [65:0] hsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      hsum[i] = 66'(p5_r[i]) + (66'(vt_r[i]) >>> FRAC_BITS);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      od_r.status          <= st5_r;
      od_r.signed_distance <= sd5_r;
      od_r.hit_x <= hit5_r ? sat32(hsum[0]) : '0;
      od_r.hit_y <= hit5_r ? sat32(hsum[1]) : '0;
      od_r.hit_z <= hit5_r ? sat32(hsum[2]) : '0;
    end
  end
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ----- rtl/core/psri_div.sv -----
// ----------------------------------------------------------------------------
// psri_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Carries a sideband word along with each division.
// ----------------------------------------------------------------------------
module psri_div import psri_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic signed [NW:0]   quo,
  output logic [SW-1:0]        side_out
);

  localparam int N = NW + 1;

  logic [N-1:0]  vld_r;
  logic [N-1:0]  rem_r  [N];
  logic [N-1:0]  q_r    [N];
  logic [DW:0]   d_r    [N];
  logic          neg_r  [N];
  logic [SW-1:0] sd_r   [N];

  logic [N-1:0] num_mag;
  logic [DW:0]  den_mag;

  // magnitudes at entry
  always_comb begin
    num_mag = num[NW-1] ? N'(-$signed({num[NW-1], num})) : N'({1'b0, num});
    den_mag = den[DW-1] ? (DW+1)'(-$signed({den[DW-1], den})) : {1'b0, den};
  end

  // one restoring step per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [N-1:0] rin, qin, rsh;
    logic [DW:0]  din;
    logic [N:0]   part, part_nxt;
    logic         ge;
    if (i == 0) begin : g_first
      assign rin = num_mag;
      assign qin = '0;
      assign din = den_mag;
    end else begin : g_rest
      assign rin = rem_r[i-1];
      assign qin = q_r[i-1];
      assign din = d_r[i-1];
    end
    // partial remainder sits in the top, dividend bits shift out from qin
    always_comb begin
      part = '0;
      rsh  = '0;
      if (i == 0) begin
        part = (N+1)'(rin[N-1]);
        rsh  = {rin[N-2:0], 1'b0};
      end else begin
        part = {rin, qin[N-1]};
        rsh  = {qin[N-2:0], 1'b0};
      end
      ge = part >= (N+1)'(din);
      part_nxt = ge ? part - (N+1)'(din) : part;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= part_nxt[N-1:0];
        q_r[i]   <= {rsh[N-1:1], ge};
        d_r[i]   <= din;
        if (i == 0) begin
          neg_r[i] <= num[NW-1] ^ den[DW-1];
          sd_r[i]  <= side_in;
        end else begin
          neg_r[i] <= neg_r[i-1];
          sd_r[i]  <= sd_r[i-1];
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign quo = neg_r[N-1] ? -$signed(q_r[N-1]) : $signed(q_r[N-1]);
  assign side_out = sd_r[N-1];

endmodule

// ----- rtl/core/psri_checker.sv -----
// ----------------------------------------------------------------------------
// psri_checker
// Port-level checks of the plane query pipeline.
// ----------------------------------------------------------------------------
module psri_checker import psri_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat changed while stalled");

  // input side stalls only behind a stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_PARALLEL)
    else $error("bad status code");

  // hit point only on hit status
  a_hitzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_HIT |->
      out_data.hit_x == 0 && out_data.hit_y == 0 && out_data.hit_z == 0)
    else $error("hit point on a miss");

endmodule

bind plane_segment_ray_intersect psri_checker u_psri_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);

// ----- verif/tb_plane_segment_ray_intersect.sv -----
// ----------------------------------------------------------------------------
// tb_plane_segment_ray_intersect
// Self-checking bench for the plane query pipeline: directed and random
// point, segment and ray queries over several plane settings, each result
// compared against a bit-exact fixed point predictor.
// ----------------------------------------------------------------------------
module tb_plane_segment_ray_intersect;
  import psri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int LATENCY   = FB + 38;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1100;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  plane_segment_ray_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // plane held by the predictor
  logic signed [63:0] pl_nx, pl_ny, pl_nz, pl_ofs, pl_tol;

  in_item_t  query_q[$];
  out_item_t result_q[$];
  int        errors = 0;
  int        wdog;
  bit        no_idle;
  bit        feed_hold;
  int        in_gap, out_gap;
  bit        seen_out;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] floor_sh(input logic signed [127:0] x);
    logic signed [127:0] r;
    r = x >>> FB;
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 64'sd2147483647;
    if (x < -128'sd2147483648) return -64'sd2147483648;
    return x[63:0];
  endfunction

  // exact floored dot product of the plane normal with a vector
  function automatic logic signed [63:0] normal_dot(input logic signed [31:0] a,
      input logic signed [31:0] b, input logic signed [31:0] c);
    logic signed [127:0] acc;
    acc = pl_nx * a + pl_ny * b + pl_nz * c;
    return floor_sh(acc);
  endfunction

  function automatic logic signed [63:0] mag(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // expected result of one query
  function automatic out_item_t plane_query(input in_item_t q);
    out_item_t r;
    logic signed [63:0] s_full, s, nv_full, nv, t;
    logic signed [127:0] num;
    logic signed [31:0] pv[3], vv[3];
    status_t st;
    pv = '{q.px, q.py, q.pz};
    vv = '{q.vx, q.vy, q.vz};
    r = '0;
    s_full = normal_dot(q.px, q.py, q.pz) + pl_ofs;
    s = clamp32(s_full);
    r.signed_distance = s[31:0];
    if (q.req_type == REQ_SEGMENT || q.req_type == REQ_RAY) begin
      nv_full = normal_dot(q.vx, q.vy, q.vz);
      if (mag(nv_full) <= pl_tol) begin
        st = (mag(s_full) <= pl_tol) ? ST_INSIDE : ST_PARALLEL;
      end else begin
        nv = clamp32(nv_full);
        num = -(s * (64'sd1 <<< FB));
        t = clamp32(num / nv);
        if (q.req_type == REQ_SEGMENT && t < 0) st = ST_BACK;
        else if (q.req_type == REQ_SEGMENT && t > (64'sd1 <<< FB)) st = ST_FRONT;
        else begin
          st = ST_HIT;
          r.hit_x = 32'(clamp32(pv[0] + floor_sh(vv[0] * t)));
          r.hit_y = 32'(clamp32(pv[1] + floor_sh(vv[1] * t)));
          r.hit_z = 32'(clamp32(pv[2] + floor_sh(vv[2] * t)));
        end
      end
    end else begin
      if (mag(s_full) <= pl_tol) st = ST_HIT;
      else if (s_full < 0) st = ST_BACK;
      else st = ST_FRONT;
    end
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver: one query beat from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) result_q.push_back(plane_query(in_data));
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (query_q.size() > 0 && !feed_hold) begin
        in_valid <= 1'b1;
        in_data  <= query_q.pop_front();
        if (!no_idle && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check result beats and pace out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("result beat with nothing expected");
          errors++;
        end else begin
          out_item_t e;
          e = result_q.pop_front();
          if (out_data.status !== e.status)
            report_mismatch("status", 32'(out_data.status), 32'(e.status));
          if (out_data.signed_distance !== e.signed_distance)
            report_mismatch("signed_distance", out_data.signed_distance, e.signed_distance);
          if (out_data.hit_x !== e.hit_x) report_mismatch("hit_x", out_data.hit_x, e.hit_x);
          if (out_data.hit_y !== e.hit_y) report_mismatch("hit_y", out_data.hit_y, e.hit_y);
          if (out_data.hit_z !== e.hit_z) report_mismatch("hit_z", out_data.hit_z, e.hit_z);
        end
      end
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        out_gap   <= $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one register beat; the caller drops cfg_valid after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NX:  pl_nx  = $signed(val);
      CFG_NY:  pl_ny  = $signed(val);
      CFG_NZ:  pl_nz  = $signed(val);
      CFG_OFS: pl_ofs = $signed(val);
      CFG_TOL: pl_tol = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic set_plane(input logic [31:0] nx, input logic [31:0] ny,
      input logic [31:0] nz, input logic [31:0] ofs, input logic [31:0] tol);
    write_reg(CFG_NX, nx);
    write_reg(CFG_NY, ny);
    write_reg(CFG_NZ, nz);
    write_reg(CFG_OFS, ofs);
    write_reg(CFG_TOL, tol);
    cfg_valid <= 1'b0;
  endtask

  // wait for every pending query and result, then the pipe depth
  task automatic drain();
    while (query_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic push_query(input req_t rt, input logic [31:0] px, input logic [31:0] py,
      input logic [31:0] pz, input logic [31:0] vx, input logic [31:0] vy,
      input logic [31:0] vz);
    in_item_t q;
    q.req_type = rt;
    q.px = px; q.py = py; q.pz = pz;
    q.vx = vx; q.vy = vy; q.vz = vz;
    query_q.push_back(q);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // random query: any request type, some aimed along or through the plane
  task automatic push_random();
    req_t rt;
    logic [31:0] p[3], v[3];
    rt = req_t'($urandom_range(0, 3));
    for (int i = 0; i < 3; i++) begin
      p[i] = rnd_coord();
      v[i] = rnd_coord();
    end
    if ($urandom_range(0, 3) == 0) begin
      // direction along the plane
      v[2] = $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 80);
      if ($urandom_range(0, 1)) p[2] = $urandom_range(0, 1) ? 32'd0 : -32'sd40;
    end else if ($urandom_range(0, 1)) begin
      // segment whose end lies near z = 0
      v[2] = -p[2] + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    end
    push_query(rt, p[0], p[1], p[2], v[0], v[1], v[2]);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NX;
    cfg_data  = '0;
    no_idle   = 1'b0;
    feed_hold = 1'b0;
    pl_nx = 0; pl_ny = 0; pl_nz = 64'sd65536; pl_ofs = 0; pl_tol = 64'sd66;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed queries on the reset plane
    push_query(REQ_POINT, 0, 0, 0, 0, 0, 0);
    push_query(REQ_POINT, 0, 0, 66, 0, 0, 0);
    push_query(REQ_POINT, 0, 0, 67, 0, 0, 0);
    push_query(REQ_POINT, 0, 0, -67, 0, 0, 0);
    push_query(REQ_SPARE, 1, 2, -32'sh0001_0000, 5, 6, 7);
    push_query(REQ_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(REQ_SEGMENT, 0, 0, 0, 32'h0001_0000, 0, 0);
    push_query(REQ_SEGMENT, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
    push_query(REQ_SEGMENT, 0, 0, -32'sh0001_0000, 0, 0, 32'h0002_0000);
    push_query(REQ_SEGMENT, 0, 0, -32'sh0001_0000, 0, 0, 32'h0001_0000);
    push_query(REQ_SEGMENT, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    push_query(REQ_SEGMENT, 0, 0, -32'sh0002_0000, 0, 0, 32'h0001_0000);
    push_query(REQ_RAY, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    push_query(REQ_RAY, 32'h7FFF_0000, 0, -32'sh7000_0000, 32'h7FFF_FFFF, 0, 32'h0000_0100);
    push_query(REQ_RAY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_query(REQ_RAY, 5, 5, 32'h7FFF_FFFF, 5, 5, 67);
    drain();

    // extreme planes, tolerance extremes; every register written
    set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    push_query(REQ_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    push_query(REQ_SEGMENT, 1, 2, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_query(REQ_RAY, 0, 0, 0, 1, 0, 0);
    push_query(REQ_RAY, 0, 0, 0, 0, 0, 0);
    drain();
    set_plane(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_query(REQ_SEGMENT, 3, 4, 5, 6, 7, 8);
    push_query(REQ_POINT, 3, 4, 5, 6, 7, 8);
    drain();

    // random phases over several planes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_plane(0, 0, 32'h0001_0000, 0, 66);
        1: set_plane(32'h0000_B505, 0, 32'h0000_B505, $urandom_range(0, 32'h0004_0000), 200);
        2: set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        3: set_plane(32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFE_0000, 0);
        default: set_plane(0, 0, 32'h0001_0000, 0, 66);
      endcase
      no_idle = (ph == 4);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        push_random();
        // sender waits out every result once, mid phase
        if (ph == 1 && k == 100) begin
          feed_hold = 1'b1;
          while (in_valid || result_q.size() > 0 || query_q.size() > 1) begin
            if (query_q.size() > 1) feed_hold = 1'b0;
            @(posedge clk);
            if (query_q.size() <= 1) feed_hold = 1'b1;
          end
          feed_hold = 1'b0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
